// File: rtl/tcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants for the text console cell writer
// Command codes, character codes, controller states and the command/status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int DEFAULT_COLUMNS = 80;
  localparam int DEFAULT_ROWS    = 25;

  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] ATTR_RESET   = 8'h0F;

  typedef enum logic [1:0] {
    FUNC_PUT   = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_SET   = 2'd2,
    FUNC_READ  = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_WRITE,
    ST_CLEAR,
    ST_SCROLL,
    ST_BLANKROW,
    ST_READ,
    ST_READWAIT,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_COL0,
    CUR_NEXT_ROW,
    CUR_INC,
    CUR_BACK,
    CUR_PREV_ROW,
    CUR_SET,
    CUR_HOME
  } cur_op_t;

  typedef enum logic [1:0] {
    WD_RESET,
    WD_BLANK,
    WD_CHAR,
    WD_COPY
  } wsrc_t;

  typedef enum logic [1:0] {
    WA_SWEEP,
    WA_COPY,
    WA_CURSOR
  } wa_t;

  typedef enum logic {
    RA_COPY,
    RA_POS
  } ra_t;

  typedef struct packed {
    logic    load;
    cur_op_t cur_op;
    logic    sweep_clr;
    logic    sweep_inc;
    logic    mem_we;
    wsrc_t   wsrc;
    wa_t     wa;
    logic    mem_re;
    ra_t     ra;
    logic    cell_load;
    logic    set_scroll;
    logic    out_load;
  } tcw_cmd_t;

  typedef struct packed {
    func_t func;
    logic  ch_newline;
    logic  ch_return;
    logic  ch_backspace;
    logic  col_zero;
    logic  col_last;
    logic  row_zero;
    logic  row_last;
    logic  sweep_zero;
    logic  sweep_copy_end;
    logic  sweep_last;
  } tcw_status_t;

endpackage

// File: rtl/tcw_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_datapath: screen store, cursor and result registers
// Holds the latched command word, the cursor, the attribute register, the
// sweep counter for clear/scroll, the cell memory and the output registers.
// ----------------------------------------------------------------------------
module tcw_datapath #(
  parameter int COLUMNS = tcw_pkg::DEFAULT_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEFAULT_ROWS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [1:0]           func,
  input  logic [7:0]           char_code,
  input  logic [7:0]           pos_x,
  input  logic [7:0]           pos_y,
  input  logic                 cfg_write,
  input  logic [7:0]           cfg_data,
  input  tcw_pkg::tcw_cmd_t    cmd,
  output tcw_pkg::tcw_status_t status,
  output logic                 done,
  output logic [6:0]           cursor_col,
  output logic [4:0]           cursor_row,
  output logic [10:0]          cursor_address,
  output logic [15:0]          cell_data,
  output logic                 did_scroll
);
  import tcw_pkg::*;

  localparam int CELLS    = ROWS * COLUMNS;
  localparam int AW       = $clog2(CELLS);
  localparam int CW       = $clog2(COLUMNS);
  localparam int RW       = $clog2(ROWS);
  localparam int COPY_END = CELLS - COLUMNS;

  func_t          func_q;
  logic [7:0]     ch_q;
  logic [CW-1:0]  px_q;
  logic [RW-1:0]  py_q;
  logic [CW-1:0]  px_sat;
  logic [RW-1:0]  py_sat;
  logic [7:0]     attr;
  logic [CW-1:0]  col;
  logic [RW-1:0]  row;
  logic [AW-1:0]  sweep;
  logic           scrolled;
  logic [15:0]    cell_q;
  logic [15:0]    mem [CELLS];
  logic [15:0]    rdata;

  logic [RW-1:0]  lin_row;
  logic [CW-1:0]  lin_col;
  logic [AW-1:0]  lin;
  logic [AW-1:0]  copy_raddr;
  logic [AW-1:0]  waddr;
  logic [AW-1:0]  raddr;
  logic [15:0]    wdata;

  // saturate coordinates on the way in
  assign px_sat = ({1'b0, pos_x} > 9'(COLUMNS - 1)) ? CW'(COLUMNS - 1) : CW'(pos_x);
  assign py_sat = ({1'b0, pos_y} > 9'(ROWS - 1))    ? RW'(ROWS - 1)    : RW'(pos_y);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q <= func_t'(func);
      ch_q   <= char_code;
      px_q   <= px_sat;
      py_q   <= py_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= ATTR_RESET;
    end else if (cfg_write) begin
      attr <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else begin
      case (cmd.cur_op)
        CUR_HOLD: begin
        end
        CUR_COL0: begin
          col <= '0;
        end
        CUR_NEXT_ROW: begin
          col <= '0;
          row <= row + 1'b1;
        end
        CUR_INC: begin
          col <= col + 1'b1;
        end
        CUR_BACK: begin
          col <= col - 1'b1;
        end
        CUR_PREV_ROW: begin
          col <= CW'(COLUMNS - 1);
          row <= row - 1'b1;
        end
        CUR_SET: begin
          col <= px_q;
          row <= py_q;
        end
        CUR_HOME: begin
          col <= '0;
          row <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep <= '0;
    end else if (cmd.sweep_clr) begin
      sweep <= '0;
    end else if (cmd.sweep_inc) begin
      sweep <= sweep + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scrolled <= 1'b0;
    end else if (cmd.set_scroll) begin
      scrolled <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cell_q <= '0;
    end else if (cmd.cell_load) begin
      cell_q <= rdata;
    end
  end

  // linear address: cursor, or the read-cell position
  assign lin_row    = (cmd.ra == RA_POS) ? py_q : row;
  assign lin_col    = (cmd.ra == RA_POS) ? px_q : col;
  assign lin        = AW'(AW'(lin_row) * AW'(COLUMNS)) + AW'(lin_col);
  assign copy_raddr = AW'({1'b0, sweep} + (AW + 1)'(COLUMNS));

  always_comb begin
    case (cmd.wa)
      WA_SWEEP:  waddr = sweep;
      WA_COPY:   waddr = sweep - 1'b1;
      WA_CURSOR: waddr = lin;
      default:   waddr = sweep;
    endcase
  end

  always_comb begin
    case (cmd.wsrc)
      WD_RESET: wdata = {ATTR_RESET, CH_SPACE};
      WD_BLANK: wdata = {attr, CH_SPACE};
      WD_CHAR:  wdata = {attr, ch_q};
      WD_COPY:  wdata = rdata;
      default:  wdata = {attr, CH_SPACE};
    endcase
  end

  assign raddr = (cmd.ra == RA_POS) ? lin : copy_raddr;

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.mem_re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      cursor_col     <= 7'(col);
      cursor_row     <= 5'(row);
      cursor_address <= 11'(lin);
      cell_data      <= cell_q;
      did_scroll     <= scrolled;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.out_load;
    end
  end

  always_comb begin
    status.func           = func_q;
    status.ch_newline     = (ch_q == CH_NEWLINE);
    status.ch_return      = (ch_q == CH_RETURN);
    status.ch_backspace   = (ch_q == CH_BACKSPACE);
    status.col_zero       = (col == '0);
    status.col_last       = (col == CW'(COLUMNS - 1));
    status.row_zero       = (row == '0);
    status.row_last       = (row == RW'(ROWS - 1));
    status.sweep_zero     = (sweep == '0);
    status.sweep_copy_end = (sweep == AW'(COPY_END));
    status.sweep_last     = (sweep == AW'(CELLS - 1));
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe held two cycles");

  a_waddr_range: assert property (@(posedge clk) disable iff (rst)
    cmd.mem_we |-> ({1'b0, waddr} < (AW + 1)'(CELLS)))
    else $error("write address beyond screen store");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (int'(col) < COLUMNS) && (int'(row) < ROWS))
    else $error("cursor outside the screen");

  a_no_collide: assert property (@(posedge clk) disable iff (rst)
    (cmd.mem_we && cmd.mem_re) |-> (waddr != raddr))
    else $error("read and write hit the same cell");

endmodule

// File: rtl/tcw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ctrl: command sequencer
// Decodes the latched command and steps the datapath through the reset fill,
// writes, the clear and scroll sweeps, cell reads and the result load.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  tcw_pkg::tcw_status_t status,
  output tcw_pkg::tcw_cmd_t    cmd,
  output logic                 busy
);
  import tcw_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (status.sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        case (status.func)
          FUNC_PUT: begin
            if (status.ch_newline) begin
              state_next = status.row_last ? ST_SCROLL : ST_FINISH;
            end else if (status.ch_return) begin
              state_next = ST_FINISH;
            end else if (status.ch_backspace) begin
              state_next = (status.col_zero && status.row_zero) ? ST_FINISH : ST_WRITE;
            end else begin
              state_next = ST_WRITE;
            end
          end
          FUNC_CLEAR: state_next = ST_CLEAR;
          FUNC_SET:   state_next = ST_FINISH;
          FUNC_READ:  state_next = ST_READ;
          default:    state_next = ST_FINISH;
        endcase
      end
      ST_WRITE: begin
        if (!status.ch_backspace && status.col_last && status.row_last) begin
          state_next = ST_SCROLL;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_CLEAR: begin
        if (status.sweep_last) state_next = ST_FINISH;
      end
      ST_SCROLL: begin
        if (status.sweep_copy_end) state_next = ST_BLANKROW;
      end
      ST_BLANKROW: begin
        if (status.sweep_last) state_next = ST_FINISH;
      end
      ST_READ:     state_next = ST_READWAIT;
      ST_READWAIT: state_next = ST_FINISH;
      ST_FINISH:   state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '{load: 1'b0, cur_op: CUR_HOLD, sweep_clr: 1'b0, sweep_inc: 1'b0,
            mem_we: 1'b0, wsrc: WD_BLANK, wa: WA_SWEEP, mem_re: 1'b0,
            ra: RA_COPY, cell_load: 1'b0, set_scroll: 1'b0, out_load: 1'b0};
    case (state)
      ST_INIT: begin
        cmd.mem_we    = 1'b1;
        cmd.wsrc      = WD_RESET;
        cmd.sweep_inc = 1'b1;
      end
      ST_IDLE: begin
        cmd.sweep_clr = 1'b1;
        cmd.load      = start;
      end
      ST_DECODE: begin
        case (status.func)
          FUNC_PUT: begin
            if (status.ch_newline) begin
              if (status.row_last) begin
                cmd.cur_op     = CUR_COL0;
                cmd.set_scroll = 1'b1;
              end else begin
                cmd.cur_op = CUR_NEXT_ROW;
              end
            end else if (status.ch_return) begin
              cmd.cur_op = CUR_COL0;
            end else if (status.ch_backspace) begin
              if (!status.col_zero) begin
                cmd.cur_op = CUR_BACK;
              end else if (!status.row_zero) begin
                cmd.cur_op = CUR_PREV_ROW;
              end
            end
          end
          FUNC_SET: cmd.cur_op = CUR_SET;
          default: begin
          end
        endcase
      end
      ST_WRITE: begin
        cmd.mem_we = 1'b1;
        cmd.wa     = WA_CURSOR;
        if (status.ch_backspace) begin
          cmd.wsrc = WD_BLANK;
        end else begin
          cmd.wsrc = WD_CHAR;
          if (status.col_last) begin
            if (status.row_last) begin
              cmd.cur_op     = CUR_COL0;
              cmd.set_scroll = 1'b1;
            end else begin
              cmd.cur_op = CUR_NEXT_ROW;
            end
          end else begin
            cmd.cur_op = CUR_INC;
          end
        end
      end
      ST_CLEAR: begin
        cmd.mem_we    = 1'b1;
        cmd.wsrc      = WD_BLANK;
        cmd.sweep_inc = 1'b1;
        if (status.sweep_last) cmd.cur_op = CUR_HOME;
      end
      ST_SCROLL: begin
        // read row below, write it in the next cycle one row up
        cmd.mem_re    = !status.sweep_copy_end;
        cmd.ra        = RA_COPY;
        cmd.mem_we    = !status.sweep_zero;
        cmd.wa        = WA_COPY;
        cmd.wsrc      = WD_COPY;
        cmd.sweep_inc = !status.sweep_copy_end;
      end
      ST_BLANKROW: begin
        cmd.mem_we    = 1'b1;
        cmd.wsrc      = WD_BLANK;
        cmd.sweep_inc = 1'b1;
      end
      ST_READ: begin
        cmd.mem_re = 1'b1;
        cmd.ra     = RA_POS;
      end
      ST_READWAIT: begin
        cmd.cell_load = 1'b1;
      end
      ST_FINISH: begin
        cmd.out_load = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

  a_accept: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && start) |=> (state == ST_DECODE))
    else $error("accepted command not decoded");

endmodule

// File: rtl/text_console_cell_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cell_writer: text-mode console engine
// Screen store of 16-bit cells (attribute high byte, character low byte) with
// a cursor; put-character, clear, set-cursor and read-cell commands.
// ----------------------------------------------------------------------------
// Usage: drive func/char_code/pos_x/pos_y and raise start; the word is taken
// at a clock edge with start high and busy low. Exactly one result word
// follows per command, shown for one cycle with done high; the receiver
// cannot stall it, so capture it on done. busy falls in the cycle that shows
// the result, so the next command can be taken in that same cycle.
// Steps from accept to the result load (screen of ROWS x COLUMNS = N cells):
//   return, newline without scroll, set cursor, blocked backspace: decode
//   printable character, backspace: decode, cell write
//   read cell: decode, one registered read of the cell memory, cell capture
//   clear: one cell written per cycle over all N cells
//   newline that scrolls; character that wraps and scrolls, after its write:
//   a copy loop reads one cell and writes one cell per cycle through the
//   single memory read/write port pair, then the last row is blanked
// After reset the block holds busy while it fills the store with blanks of
// attribute 0x0F. cfg_write/cfg_data set the attribute byte used for written
// and blanked cells; write it while idle. Outputs carry the cursor after the
// command, its linear address row * COLUMNS + column, the cell read (zero for
// other commands) and a flag set when the screen scrolled up one row.
// ----------------------------------------------------------------------------
module text_console_cell_writer #(
  parameter int COLUMNS = tcw_pkg::DEFAULT_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEFAULT_ROWS
) (
  input  logic        clk,
  input  logic        rst,
  // command word
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [7:0]  char_code,
  input  logic [7:0]  pos_x,
  input  logic [7:0]  pos_y,
  // attribute register
  input  logic        cfg_write,
  input  logic [7:0]  cfg_data,
  // result word
  output logic        done,
  output logic [6:0]  cursor_col,
  output logic [4:0]  cursor_row,
  output logic [10:0] cursor_address,
  output logic [15:0] cell_data,
  output logic        did_scroll
);
  import tcw_pkg::*;

  tcw_cmd_t    cmd;
  tcw_status_t status;

  // sequencer: decodes the command, runs sweeps
  tcw_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // cursor, attribute, cell memory and result registers
  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .func           (func),
    .char_code      (char_code),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .status         (status),
    .done           (done),
    .cursor_col     (cursor_col),
    .cursor_row     (cursor_row),
    .cursor_address (cursor_address),
    .cell_data      (cell_data),
    .did_scroll     (did_scroll)
  );

endmodule
